// ===== hw/rtl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master package
// Shared request and result types, register map and phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_RESET = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_POLL  = 3'd4
  } cmd_t;

  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_RST_LOW   = 11'b000_0000_0010,
    PH_RST_W1    = 11'b000_0000_0100,
    PH_RST_W2    = 11'b000_0000_1000,
    PH_PULSE     = 11'b000_0001_0000,
    PH_W_BODY    = 11'b000_0010_0000,
    PH_RD_WAIT   = 11'b000_0100_0000,
    PH_RD_TAIL   = 11'b000_1000_0000,
    PH_POLL_WAIT = 11'b001_0000_0000,
    PH_POLL_TAIL = 11'b010_0000_0000,
    PH_RECOVERY  = 11'b100_0000_0000
  } phase_t;

  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_PULSE         = 3'd2;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd3;
  localparam logic [2:0] REG_SLOT          = 3'd4;
  localparam logic [2:0] REG_RECOVERY      = 3'd5;
  localparam logic [2:0] REG_POLL_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_POLL_TAIL     = 3'd7;

  localparam logic [3:0] HIGH_COUNT_DONE = 4'd8;
  localparam logic [2:0] LAST_BIT        = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       line_in;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } owbm_out_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_wait_ticks;
    logic [7:0]  pulse_ticks;
    logic [7:0]  read_sample_ticks;
    logic [15:0] slot_ticks;
    logic [7:0]  recovery_ticks;
    logic [7:0]  poll_sample_ticks;
    logic [15:0] poll_tail_ticks;
  } owbm_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/owbm_regs.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master register file
// APB-style timing registers with read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_regs import owbm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output owbm_cfg_t        cfg
);

  owbm_cfg_t  cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[4:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= 16'd500;
      cfg_r.presence_wait_ticks <= 16'd50;
      cfg_r.pulse_ticks         <= 8'd1;
      cfg_r.read_sample_ticks   <= 8'd1;
      cfg_r.slot_ticks          <= 16'd60;
      cfg_r.recovery_ticks      <= 8'd1;
      cfg_r.poll_sample_ticks   <= 8'd10;
      cfg_r.poll_tail_ticks     <= 16'd40;
    end else if (wr_en) begin
      unique case (idx)
        REG_RESET_LOW:     cfg_r.reset_low_ticks     <= pwdata[15:0];
        REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks <= pwdata[15:0];
        REG_PULSE:         cfg_r.pulse_ticks         <= pwdata[7:0];
        REG_READ_SAMPLE:   cfg_r.read_sample_ticks   <= pwdata[7:0];
        REG_SLOT:          cfg_r.slot_ticks          <= pwdata[15:0];
        REG_RECOVERY:      cfg_r.recovery_ticks      <= pwdata[7:0];
        REG_POLL_SAMPLE:   cfg_r.poll_sample_ticks   <= pwdata[7:0];
        REG_POLL_TAIL:     cfg_r.poll_tail_ticks     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RESET_LOW:     prdata = {16'd0, cfg_r.reset_low_ticks};
      REG_PRESENCE_WAIT: prdata = {16'd0, cfg_r.presence_wait_ticks};
      REG_PULSE:         prdata = {24'd0, cfg_r.pulse_ticks};
      REG_READ_SAMPLE:   prdata = {24'd0, cfg_r.read_sample_ticks};
      REG_SLOT:          prdata = {16'd0, cfg_r.slot_ticks};
      REG_RECOVERY:      prdata = {24'd0, cfg_r.recovery_ticks};
      REG_POLL_SAMPLE:   prdata = {24'd0, cfg_r.poll_sample_ticks};
      REG_POLL_TAIL:     prdata = {16'd0, cfg_r.poll_tail_ticks};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/owbm_core.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master sequencer
// Phase state, tick timer and bit shifter, advanced once per request.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_core import owbm_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  owbm_in_t       req,
  input  owbm_cfg_t      cfg,
  output owbm_out_t      res
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  typedef logic [TIMER_BITS-1:0] tmr_t;

  typedef struct packed {
    phase_t     phase;
    tmr_t       timer;
    logic [2:0] bit_idx;
    logic [7:0] shift;
    logic       pres;
    logic [3:0] hcnt;
    cmd_t       cmd;
    logic [7:0] rhold;
    logic       fin;
  } st_t;

  typedef struct packed {
    tmr_t rst_low;
    tmr_t pwait;
    tmr_t pulse;
    tmr_t rds;
    tmr_t slot;
    tmr_t rec;
    tmr_t psmp;
    tmr_t ptail;
  } dur_t;

  st_t  st_r;
  st_t  st_nxt;
  dur_t dur;
  logic rejected;

  function automatic tmr_t sat(input logic [15:0] v, input logic min1);
    logic [32:0] e;
    e = {17'd0, v};
    if (min1 && v == 16'd0) e = 33'd1;
    if (e > TMAX) return '1;
    return e[TIMER_BITS-1:0];
  endfunction

  function automatic st_t finish(input st_t s);
    st_t r;
    r       = s;
    r.phase = PH_IDLE;
    r.cmd   = CMD_NONE;
    r.timer = '0;
    r.fin   = 1'b1;
    return r;
  endfunction

  function automatic st_t next_slot(input st_t s, input dur_t d);
    st_t r;
    r = s;
    if (s.bit_idx == LAST_BIT) begin
      if (s.cmd == CMD_READ) r.rhold = s.shift;
      r = finish(r);
    end else begin
      r.bit_idx = s.bit_idx + 3'd1;
      r.phase   = PH_RECOVERY;
      r.timer   = d.rec;
    end
    return r;
  endfunction

  function automatic st_t end_step(input st_t s, input dur_t d, input logic line);
    st_t r;
    r = s;
    unique case (s.phase)
      PH_RST_LOW: begin
        r.phase = PH_RST_W1;
        r.timer = d.pwait;
      end
      PH_RST_W1: begin
        if (line) begin
          r.pres = 1'b0;
          r = finish(r);
        end else begin
          r.phase = PH_RST_W2;
          r.timer = d.pwait;
        end
      end
      PH_RST_W2: begin
        r.pres = ~line;
        r = finish(r);
      end
      PH_PULSE: begin
        if (s.cmd == CMD_WRITE) begin
          r.phase = PH_W_BODY;
          r.timer = d.slot;
        end else if (s.cmd == CMD_READ) begin
          r.phase = PH_RD_WAIT;
          r.timer = d.rds;
        end else begin
          r.phase = PH_POLL_WAIT;
          r.timer = d.psmp;
        end
      end
      PH_W_BODY: begin
        r.shift = {1'b0, s.shift[7:1]};
        r = next_slot(r, d);
      end
      PH_RD_WAIT: begin
        r.shift = {line, s.shift[7:1]};
        r.phase = PH_RD_TAIL;
        r.timer = d.slot;
      end
      PH_RD_TAIL: r = next_slot(r, d);
      PH_POLL_WAIT: begin
        if (line && s.hcnt < HIGH_COUNT_DONE) r.hcnt = s.hcnt + 4'd1;
        r.phase = PH_POLL_TAIL;
        r.timer = d.ptail;
      end
      PH_POLL_TAIL: begin
        if (s.hcnt >= HIGH_COUNT_DONE) begin
          r = finish(r);
        end else begin
          r.phase = PH_RECOVERY;
          r.timer = d.rec;
        end
      end
      PH_RECOVERY: begin
        r.phase = PH_PULSE;
        r.timer = d.pulse;
      end
      default: r = finish(r);
    endcase
    return r;
  endfunction

  always_comb begin
    dur.rst_low = sat(cfg.reset_low_ticks, 1'b1);
    dur.pwait   = sat(cfg.presence_wait_ticks, 1'b1);
    dur.pulse   = sat({8'd0, cfg.pulse_ticks}, 1'b1);
    dur.rds     = sat({8'd0, cfg.read_sample_ticks}, 1'b0);
    dur.slot    = sat(cfg.slot_ticks, 1'b1);
    dur.rec     = sat({8'd0, cfg.recovery_ticks}, 1'b0);
    dur.psmp    = sat({8'd0, cfg.poll_sample_ticks}, 1'b0);
    dur.ptail   = sat(cfg.poll_tail_ticks, 1'b1);
  end

  // A tick ends at most two phases: only a zero-length sample wait or
  // recovery can follow the phase whose timer ran out.
  always_comb begin
    logic is_cmd;
    logic busy;
    st_t  s;
    s        = st_r;
    s.fin    = 1'b0;
    rejected = 1'b0;
    busy     = (st_r.phase != PH_IDLE);
    is_cmd   = (req.action == CMD_RESET) || (req.action == CMD_WRITE) ||
               (req.action == CMD_READ) || (req.action == CMD_POLL);
    if (is_cmd) begin
      if (busy) begin
        rejected = 1'b1;
      end else begin
        s.cmd     = cmd_t'(req.action);
        s.bit_idx = 3'd0;
        s.hcnt    = 4'd0;
        if (req.action == CMD_RESET) begin
          s.phase = PH_RST_LOW;
          s.timer = dur.rst_low;
        end else begin
          s.shift = (req.action == CMD_WRITE) ? req.data_byte : 8'd0;
          s.phase = PH_PULSE;
          s.timer = dur.pulse;
        end
      end
    end else if (busy) begin
      if (s.timer != '0) s.timer = s.timer - tmr_t'(1);
      if (s.timer == '0) s = end_step(s, dur, req.line_in);
      if (s.phase != PH_IDLE && s.timer == '0) s = end_step(s, dur, req.line_in);
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= PH_IDLE;
      st_r.timer   <= '0;
      st_r.bit_idx <= 3'd0;
      st_r.shift   <= 8'd0;
      st_r.pres    <= 1'b0;
      st_r.hcnt    <= 4'd0;
      st_r.cmd     <= CMD_NONE;
      st_r.rhold   <= 8'd0;
      st_r.fin     <= 1'b0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign res.drive_low = (st_nxt.phase == PH_RST_LOW) || (st_nxt.phase == PH_PULSE) ||
                         ((st_nxt.phase == PH_W_BODY) && !st_nxt.shift[0]);
  assign res.busy_res  = (st_nxt.phase != PH_IDLE);
  assign res.done_res  = st_nxt.fin;
  assign res.presence  = st_nxt.pres;
  assign res.read_data = st_nxt.rhold;
  assign res.rejected  = rejected;

endmodule

`default_nettype wire

// ===== hw/rtl/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master unit
// Tick-driven master for a single-wire open-drain bus.
// ----------------------------------------------------------------------------
// Each request on the input channel is either one time tick or a command
// (bus reset, write byte, read byte, poll until ready) together with the
// sampled line level. Every request gives exactly one result carrying the
// line drive, the busy and done flags, the presence flag, the last byte read
// and a rejection flag for a command that arrived while busy.
// A request passes an input register and is then handled by the sequencer,
// whose result is captured in the output register; one request is taken
// every cycle while the receiver does not stall. When the receiver stalls,
// the result is held in the output register and the input stalls once its
// register is full. The user writes the timing registers over the APB port
// only while no command is running; the block itself does not enforce it.
// Each phase reads its length as it begins. A synchronous reset empties both
// registers, returns the sequencer to idle and loads the default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_unit import owbm_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  owbm_in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output owbm_out_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  owbm_cfg_t cfg;
  owbm_in_t  req_r;
  logic      req_valid_r;
  owbm_out_t res;
  owbm_out_t out_data_r;
  logic      out_valid_r;
  logic      adv;
  logic      step_en;

  assign adv      = ~out_valid_r | ~out_stall;
  assign step_en  = req_valid_r & adv;
  assign in_stall = req_valid_r & ~adv;
  assign pready   = 1'b1;

  owbm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  owbm_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .req     (req_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/owbm_checker.sv =====
// ----------------------------------------------------------------------------
// One-wire bus master checker
// Port-level assertions on results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_checker import owbm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input owbm_out_t        out_data
);

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("command finished but still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |-> out_data.busy_res && !out_data.done_res)
    else $error("rejected request while idle or finishing");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_low |-> out_data.busy_res)
    else $error("line driven low while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

`default_nettype wire
